### sv/lrd_pkg.sv
// shared types and codes for the log record deframer
// no dependencies; compile before every other file
package lrd_pkg;

    // one transaction on the byte channel
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    // one transaction on the result channel
    typedef struct packed {
        logic [3:0]  byte_role;
        logic [7:0]  byte_out;
        logic [2:0]  status;
        logic [7:0]  op_code;
        logic [63:0] time_stamp;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [31:0] recovered_count;
        logic        corrupted_flag;
    } out_item_t;

    // parse phases, numbered to match the byte role codes
    typedef enum logic [3:0] {
        PH_SIZE  = 4'd0,
        PH_OP    = 4'd1,
        PH_STAMP = 4'd2,
        PH_KLEN  = 4'd3,
        PH_KEY   = 4'd4,
        PH_VLEN  = 4'd5,
        PH_VAL   = 4'd6,
        PH_SPARE = 4'd7,
        PH_CRC   = 4'd8
    } phase_t;

    localparam logic [3:0] ROLE_IGNORED = 4'd9;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_CLEAN_END = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_CRC_BAD   = 3'd4;
    localparam logic [2:0] ST_MALFORMED = 3'd5;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    localparam logic [3:0] SIZE_BYTES  = 4'd4;
    localparam logic [3:0] STAMP_BYTES = 4'd8;
    localparam logic [3:0] LEN_BYTES   = 4'd4;
    localparam logic [3:0] CRC_BYTES   = 4'd4;

endpackage

### sv/lrd_crc_byte.sv
// one byte step of reflected crc-32 (poly 0xEDB88320)
// depends on lrd_pkg
module lrd_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import lrd_pkg::*;

    logic [31:0] c;

    // eight shift-and-xor steps on the low byte, then fold in the rest
    always_comb
    begin
        c = {24'd0, crc_in[7:0] ^ data_in};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        crc_out = c ^ (crc_in >> 8);
    end

endmodule

### sv/lrd_parser.sv
// entry parser: framing state, length checks, crc verdict and counters
// depends on lrd_pkg and lrd_crc_byte
module lrd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lrd_pkg::in_item_t item,
    output lrd_pkg::out_item_t result
);
    import lrd_pkg::*;

    phase_t      phase_reg, phase_next, rec_next;
    logic [3:0]  fbc_reg, fbc_next, fbc_inc;
    logic [31:0] length_reg, length_next, length_shift;
    logic [31:0] remain_reg, remain_next, remain_dec;
    logic [31:0] count_reg, count_next, count_dec;
    logic [31:0] crc_reg, crc_next, crc_step;
    logic [31:0] stored_reg, stored_next, stored_shift;
    logic [7:0]  opcode_reg, opcode_next;
    logic [63:0] stamp_reg, stamp_next, stamp_shift;
    logic [31:0] key_len_reg, key_len_next, key_shift;
    logic [31:0] val_len_reg, val_len_next, val_shift;
    logic        malformed_reg, malformed_next;
    logic        stopped_reg, stopped_next;
    logic [31:0] total_reg, total_next;
    logic        corrupt_reg, corrupt_next;
    logic [3:0]  role;
    logic [2:0]  status;
    logic        accepted;
    logic [7:0]  b;

    assign b = item.data_byte;

    lrd_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (b),
        .crc_out (crc_step)
    );

    // shifted field values and counters
    assign fbc_inc      = fbc_reg + 4'd1;
    assign remain_dec   = remain_reg - 32'd1;
    assign count_dec    = count_reg - 32'd1;
    assign length_shift = {length_reg[23:0], b};
    assign stored_shift = {stored_reg[23:0], b};
    assign stamp_shift  = {stamp_reg[55:0], b};
    assign key_shift    = {key_len_reg[23:0], b};
    assign val_shift    = {val_len_reg[23:0], b};

    // next state and result for one transaction
    always_comb
    begin
        phase_next     = phase_reg;
        rec_next       = phase_reg;
        fbc_next       = fbc_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        count_next     = count_reg;
        crc_next       = crc_reg;
        stored_next    = stored_reg;
        opcode_next    = opcode_reg;
        stamp_next     = stamp_reg;
        key_len_next   = key_len_reg;
        val_len_next   = val_len_reg;
        malformed_next = malformed_reg;
        stopped_next   = stopped_reg;
        total_next     = total_reg;
        corrupt_next   = corrupt_reg;
        role           = ROLE_IGNORED;
        status         = ST_BUSY;
        accepted       = 1'b0;

        if (step && !stopped_reg)
        begin
            if (item.kind == KIND_END)
            begin
                // end of stream: clean whenever in the size phase, even partway through a size header
                if (phase_reg == PH_SIZE)
                begin
                    status = ST_CLEAN_END;
                end
                else
                begin
                    status       = ST_TRUNCATED;
                    corrupt_next = 1'b1;
                end
                stopped_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SIZE:
                    begin
                        role        = PH_SIZE;
                        length_next = length_shift;
                        fbc_next    = fbc_inc;
                        if (fbc_inc >= SIZE_BYTES)
                        begin
                            fbc_next       = 4'd0;
                            remain_next    = length_shift;
                            crc_next       = CRC_ONES;
                            stored_next    = 32'd0;
                            opcode_next    = 8'd0;
                            stamp_next     = 64'd0;
                            key_len_next   = 32'd0;
                            val_len_next   = 32'd0;
                            malformed_next = 1'b0;
                            if (length_shift == 32'd0)
                            begin
                                malformed_next = 1'b1;
                                phase_next     = PH_CRC;
                            end
                            else
                            begin
                                phase_next = PH_OP;
                            end
                        end
                    end
                    PH_CRC:
                    begin
                        role        = PH_CRC;
                        stored_next = stored_shift;
                        fbc_next    = fbc_inc;
                        if (fbc_inc >= CRC_BYTES)
                        begin
                            fbc_next = 4'd0;
                            if ((crc_reg ^ CRC_ONES) != stored_shift)
                            begin
                                status       = ST_CRC_BAD;
                                corrupt_next = 1'b1;
                                stopped_next = 1'b1;
                            end
                            else if (malformed_reg)
                            begin
                                status       = ST_MALFORMED;
                                stopped_next = 1'b1;
                            end
                            else
                            begin
                                status   = ST_ACCEPTED;
                                accepted = 1'b1;
                                if (total_reg != CRC_ONES)
                                begin
                                    total_next = total_reg + 32'd1;
                                end
                            end
                            phase_next  = PH_SIZE;
                            length_next = 32'd0;
                        end
                    end
                    default:
                    begin
                        // record byte
                        role        = phase_reg;
                        crc_next    = crc_step;
                        remain_next = remain_dec;
                        unique case (phase_reg)
                            PH_OP:
                            begin
                                opcode_next = b;
                                rec_next    = PH_STAMP;
                                fbc_next    = 4'd0;
                            end
                            PH_STAMP:
                            begin
                                stamp_next = stamp_shift;
                                fbc_next   = fbc_inc;
                                if (fbc_inc >= STAMP_BYTES)
                                begin
                                    rec_next = PH_KLEN;
                                    fbc_next = 4'd0;
                                end
                            end
                            PH_KLEN:
                            begin
                                key_len_next = key_shift;
                                fbc_next     = fbc_inc;
                                if (fbc_inc >= LEN_BYTES)
                                begin
                                    fbc_next = 4'd0;
                                    if (key_shift > remain_dec)
                                    begin
                                        malformed_next = 1'b1;
                                        rec_next       = PH_SPARE;
                                    end
                                    else if (key_shift != 32'd0)
                                    begin
                                        rec_next   = PH_KEY;
                                        count_next = key_shift;
                                    end
                                    else
                                    begin
                                        rec_next = PH_VLEN;
                                    end
                                end
                            end
                            PH_KEY:
                            begin
                                count_next = count_dec;
                                if (count_dec == 32'd0)
                                begin
                                    rec_next = PH_VLEN;
                                end
                            end
                            PH_VLEN:
                            begin
                                val_len_next = val_shift;
                                fbc_next     = fbc_inc;
                                if (fbc_inc >= LEN_BYTES)
                                begin
                                    fbc_next = 4'd0;
                                    if (val_shift > remain_dec)
                                    begin
                                        malformed_next = 1'b1;
                                        rec_next       = PH_SPARE;
                                    end
                                    else if (val_shift != 32'd0)
                                    begin
                                        rec_next   = PH_VAL;
                                        count_next = val_shift;
                                    end
                                    else
                                    begin
                                        rec_next = PH_SPARE;
                                    end
                                end
                            end
                            PH_VAL:
                            begin
                                count_next = count_dec;
                                if (count_dec == 32'd0)
                                begin
                                    rec_next = PH_SPARE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        phase_next = rec_next;
                        // last record byte: move to the crc trailer
                        if (remain_dec == 32'd0)
                        begin
                            if (rec_next != PH_SPARE)
                            begin
                                malformed_next = 1'b1;
                            end
                            phase_next  = PH_CRC;
                            fbc_next    = 4'd0;
                            stored_next = 32'd0;
                        end
                    end
                endcase
            end
        end

        result.byte_role       = role;
        result.byte_out        = (item.kind == KIND_END) ? 8'd0 : b;
        result.status          = status;
        result.op_code         = accepted ? opcode_reg : 8'd0;
        result.time_stamp      = accepted ? stamp_reg : 64'd0;
        result.key_length      = accepted ? key_len_reg : 32'd0;
        result.value_length    = accepted ? val_len_reg : 32'd0;
        result.recovered_count = total_next;
        result.corrupted_flag  = corrupt_next;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            fbc_reg       <= 4'd0;
            length_reg    <= 32'd0;
            remain_reg    <= 32'd0;
            count_reg     <= 32'd0;
            crc_reg       <= CRC_ONES;
            stored_reg    <= 32'd0;
            opcode_reg    <= 8'd0;
            stamp_reg     <= 64'd0;
            key_len_reg   <= 32'd0;
            val_len_reg   <= 32'd0;
            malformed_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            total_reg     <= 32'd0;
            corrupt_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            fbc_reg       <= fbc_next;
            length_reg    <= length_next;
            remain_reg    <= remain_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            stored_reg    <= stored_next;
            opcode_reg    <= opcode_next;
            stamp_reg     <= stamp_next;
            key_len_reg   <= key_len_next;
            val_len_reg   <= val_len_next;
            malformed_reg <= malformed_next;
            stopped_reg   <= stopped_next;
            total_reg     <= total_next;
            corrupt_reg   <= corrupt_next;
        end
    end

endmodule

### sv/log_record_deframer_crc32.sv
// Log record deframer with CRC-32 check.
// Byte channel (byte_valid/byte_stall/byte_item): one transaction per log
// byte (kind 0) or one end-of-stream marker (kind 1). Result channel
// (result_valid/result_stall/result_item): exactly one result per byte
// transaction, in order, carrying the byte role, the byte, the entry verdict
// and the running counters.
// A byte passes the input register, then the parser and result register.
// Throughput: one transaction per cycle while the result side does not stall;
// the parser updates its whole state from one byte through one CRC byte step
// and 32-bit length compares.
// A stall on the result side holds the result register; the input register
// takes one more transaction if it is empty, then byte_stall rises until the
// result moves on. Nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to waiting for a size header with the CRC at all ones, the entry
// count at zero and the corrupted flag clear. After any failure verdict or
// end of stream the parser tags every byte ignored until the next reset.
// depends on lrd_pkg, lrd_parser, lrd_crc_byte
module log_record_deframer_crc32 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  lrd_pkg::in_item_t  byte_item,
    output logic               result_valid,
    input  logic               result_stall,
    output lrd_pkg::out_item_t result_item
);
    import lrd_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t parsed;
    logic      out_free;
    logic      in_free;
    logic      step;

    // pipeline flow control
    assign out_free   = !out_valid_reg || !result_stall;
    assign in_free    = !in_valid_reg || out_free;
    assign step       = in_valid_reg && out_free;
    assign byte_stall = !in_free;

    lrd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .result (parsed)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && byte_valid)
        begin
            in_item_reg <= byte_item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= parsed;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule
